// ----- src/bmhq_pkg.sv -----
// Shared types and constants for the binary min-heap priority queue.
`default_nettype none
package bmhq_pkg;

   localparam int KEY_W   = 32;
   localparam int VERT_W  = 16;
   localparam int COUNT_W = 11;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic OPC_PUSH = 1'b0;
   localparam logic OPC_POP  = 1'b1;

   typedef struct packed {
      logic                     opcode;
      logic signed [KEY_W-1:0]  new_key;
      logic [VERT_W-1:0]        new_source;
      logic [VERT_W-1:0]        new_dest;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [KEY_W-1:0]  removed_key;
      logic [VERT_W-1:0]        removed_source;
      logic [VERT_W-1:0]        removed_dest;
      logic signed [KEY_W-1:0]  top_key;
      logic [VERT_W-1:0]        top_source;
      logic [VERT_W-1:0]        top_dest;
      logic [COUNT_W-1:0]       entry_count;
      logic                     heap_empty;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]  key;
      logic [VERT_W-1:0]        source;
      logic [VERT_W-1:0]        dest;
   } entry_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PUSH_INIT,
      OP_POP_READ,
      OP_POP_INIT,
      OP_UP_READ,
      OP_UP_STEP,
      OP_DOWN_READ,
      OP_DOWN_STEP,
      OP_PLACE,
      OP_TOP_READ,
      OP_RESPOND
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic refused;
      logic is_pop;
      logic single;
      logic at_root;
      logic has_left;
      logic up_swap;
      logic down_swap;
   } flags_type;

endpackage
`default_nettype wire

// ----- src/bmhq_dpath.sv -----
// Heap datapath: entry memory, sift registers, count and result register.
`default_nettype none
module bmhq_dpath #(
   parameter int CAPACITY = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bmhq_pkg::cmd_type cmd,
   input  wire bmhq_pkg::req_type req_data,
   output bmhq_pkg::flags_type    flags,
   output bmhq_pkg::rsp_type      rsp_data
);
   import bmhq_pkg::*;

   localparam int AW = $clog2(CAPACITY + 1);

   entry_type heap_mem [0:CAPACITY];

   logic [AW-1:0]      total_ff;
   logic [AW-1:0]      pos_ff;
   entry_type          cur_ff;
   logic               opcode_ff;
   logic [1:0]         status_ff;
   entry_type          removed_ff;
   entry_type          rd_a_ff;
   entry_type          rd_b_ff;
   rsp_type            rsp_ff;

   logic [AW-1:0]      parent_pos;
   logic [AW:0]        left_pos;
   logic [AW:0]        right_pos;
   logic [AW:0]        total_x;
   logic               has_left;
   logic               has_right;
   logic               pick_right;
   entry_type          child;
   logic [AW-1:0]      child_pos;
   logic               up_swap;
   logic               down_swap;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   entry_type          mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_ra;
   logic [AW-1:0]      mem_rb;

   assign parent_pos = pos_ff >> 1;
   assign left_pos   = {pos_ff, 1'b0};
   assign right_pos  = {pos_ff, 1'b1};
   assign total_x    = {1'b0, total_ff};
   assign has_left   = (left_pos <= total_x);
   assign has_right  = (right_pos <= total_x);
   assign pick_right = has_right && (rd_b_ff.key < rd_a_ff.key);
   assign child      = pick_right ? rd_b_ff : rd_a_ff;
   assign child_pos  = pick_right ? right_pos[AW-1:0] : left_pos[AW-1:0];
   assign up_swap    = (cur_ff.key < rd_a_ff.key);
   assign down_swap  = (child.key < cur_ff.key);

   always_comb begin
      flags.refused   = (status_ff != STATUS_DONE);
      flags.is_pop    = (opcode_ff == OPC_POP);
      flags.single    = (total_ff == AW'(1));
      flags.at_root   = (pos_ff == AW'(1));
      flags.has_left  = has_left;
      flags.up_swap   = up_swap;
      flags.down_swap = down_swap;
   end

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = cur_ff;
      mem_re    = 1'b0;
      mem_ra    = AW'(1);
      mem_rb    = total_ff;
      case (cmd.op)
         OP_PLACE: begin
            mem_we = 1'b1;
         end
         OP_UP_STEP: begin
            mem_we    = 1'b1;
            mem_wdata = up_swap ? rd_a_ff : cur_ff;
         end
         OP_DOWN_STEP: begin
            mem_we    = 1'b1;
            mem_wdata = down_swap ? child : cur_ff;
         end
         OP_UP_READ: begin
            mem_re = 1'b1;
            mem_ra = parent_pos;
         end
         OP_POP_READ: begin
            mem_re = 1'b1;
         end
         OP_DOWN_READ: begin
            mem_re = 1'b1;
            mem_ra = left_pos[AW-1:0];
            mem_rb = right_pos[AW-1:0];
         end
         OP_TOP_READ: begin
            mem_re = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_a_ff <= heap_mem[mem_ra];
         rd_b_ff <= heap_mem[mem_rb];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         case (cmd.op)
            OP_PUSH_INIT: total_ff <= total_ff + AW'(1);
            OP_POP_INIT:  total_ff <= total_ff - AW'(1);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            cur_ff.key    <= req_data.new_key;
            cur_ff.source <= req_data.new_source;
            cur_ff.dest   <= req_data.new_dest;
            opcode_ff     <= req_data.opcode;
            removed_ff    <= '0;
            if (req_data.opcode == OPC_PUSH && total_ff == AW'(CAPACITY)) begin
               status_ff <= STATUS_FULL;
            end else if (req_data.opcode == OPC_POP && total_ff == '0) begin
               status_ff <= STATUS_EMPTY;
            end else begin
               status_ff <= STATUS_DONE;
            end
         end
         OP_PUSH_INIT: begin
            pos_ff <= total_ff + AW'(1);
         end
         OP_POP_INIT: begin
            removed_ff <= rd_a_ff;
            cur_ff     <= rd_b_ff;
            pos_ff     <= AW'(1);
         end
         OP_UP_STEP: begin
            if (up_swap) begin
               pos_ff <= parent_pos;
            end
         end
         OP_DOWN_STEP: begin
            if (down_swap) begin
               pos_ff <= child_pos;
            end
         end
         OP_RESPOND: begin
            rsp_ff.status         <= status_ff;
            rsp_ff.removed_key    <= removed_ff.key;
            rsp_ff.removed_source <= removed_ff.source;
            rsp_ff.removed_dest   <= removed_ff.dest;
            if (total_ff != '0) begin
               rsp_ff.top_key    <= rd_a_ff.key;
               rsp_ff.top_source <= rd_a_ff.source;
               rsp_ff.top_dest   <= rd_a_ff.dest;
            end else begin
               rsp_ff.top_key    <= '0;
               rsp_ff.top_source <= '0;
               rsp_ff.top_dest   <= '0;
            end
            rsp_ff.entry_count <= COUNT_W'(total_ff);
            rsp_ff.heap_empty  <= (total_ff == '0);
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ----- src/bmhq_ctrl.sv -----
// Heap controller: sequences load, sift up/down, top read and response.
`default_nettype none
module bmhq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire bmhq_pkg::flags_type flags,
   output bmhq_pkg::cmd_type        cmd
);
   import bmhq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_UP_CHK,
      ST_UP_STEP,
      ST_POP_RD,
      ST_POP_INIT,
      ST_DN_CHK,
      ST_DN_STEP,
      ST_TOP_RD,
      ST_RESPOND
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_slot_free;

   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (flags.refused) begin
               state_in = ST_TOP_RD;
            end else if (flags.is_pop) begin
               state_in = ST_POP_RD;
            end else begin
               cmd.op   = OP_PUSH_INIT;
               state_in = ST_UP_CHK;
            end
         end
         ST_UP_CHK: begin
            if (flags.at_root) begin
               cmd.op   = OP_PLACE;
               state_in = ST_TOP_RD;
            end else begin
               cmd.op   = OP_UP_READ;
               state_in = ST_UP_STEP;
            end
         end
         ST_UP_STEP: begin
            cmd.op   = OP_UP_STEP;
            state_in = flags.up_swap ? ST_UP_CHK : ST_TOP_RD;
         end
         ST_POP_RD: begin
            cmd.op   = OP_POP_READ;
            state_in = ST_POP_INIT;
         end
         ST_POP_INIT: begin
            cmd.op   = OP_POP_INIT;
            state_in = flags.single ? ST_TOP_RD : ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (flags.has_left) begin
               cmd.op   = OP_DOWN_READ;
               state_in = ST_DN_STEP;
            end else begin
               cmd.op   = OP_PLACE;
               state_in = ST_TOP_RD;
            end
         end
         ST_DN_STEP: begin
            cmd.op   = OP_DOWN_STEP;
            state_in = flags.down_swap ? ST_DN_CHK : ST_TOP_RD;
         end
         ST_TOP_RD: begin
            cmd.op   = OP_TOP_READ;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (rsp_slot_free) begin
               cmd.op   = OP_RESPOND;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.op == OP_RESPOND) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- src/binary_min_heap_queue_top.sv -----
// Top level of the binary min-heap priority queue.
// Steps from accept to response valid: load, decide, then sift-up for a push, or pop read,
//   pop init and sift-down for a pop (a refused request skips these); each sift swap is a
//   read, then a compare and write; then top read and respond. One transaction at a time,
//   accepted the cycle after the previous response is registered. A new one is taken while
//   that response waits in the output register; the next one stalls in its response step.
// Reset clears the entry count and the handshake state; memory contents are not cleared.
`default_nettype none
module binary_min_heap_queue_top #(
   parameter int CAPACITY = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bmhq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bmhq_pkg::rsp_type      rsp_data
);
   import bmhq_pkg::*;

   // controller <-> datapath command and status
   cmd_type   cmd;
   flags_type flags;

   // Controller: walks each transaction through load, sift-up or sift-down,
   // a final read of the root, and the response register handoff.
   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   // Datapath: one-based heap memory, the moving entry and its slot,
   // the entry count and the response register.
   bmhq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .flags    (flags),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ----- bench/bmhq_tb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard class: shadow min-heap predictor plus the queue of awaited responses.
package bmhq_tb_pkg;
   import bmhq_pkg::*;

   localparam int unsigned HEAP_DEPTH = 1024;

   class heap_shadow;
      entry_type   slots [1:HEAP_DEPTH];
      int unsigned fill;
      rsp_type     awaited [$];
      int unsigned mismatches;

      function new();
         fill       = 0;
         mismatches = 0;
      endfunction

      function int unsigned held();
         return fill;
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      function void swap(int unsigned a, int unsigned b);
         entry_type t;
         t        = slots[a];
         slots[a] = slots[b];
         slots[b] = t;
      endfunction

      // move up while strictly smaller than the parent
      function void rise(int unsigned pos);
         while (pos > 1) begin
            if (!(slots[pos].key < slots[pos >> 1].key)) break;
            swap(pos, pos >> 1);
            pos = pos >> 1;
         end
      endfunction

      // move the root down; left child wins ties
      function void sink();
         int unsigned pos;
         int unsigned left;
         int unsigned child;
         pos = 1;
         while (pos < fill) begin
            left = pos * 2;
            if (left + 1 <= fill) begin
               child = (slots[left + 1].key < slots[left].key) ? left + 1 : left;
            end else if (left == fill) begin
               child = left;
            end else begin
               break;
            end
            if (!(slots[child].key < slots[pos].key)) break;
            swap(pos, child);
            pos = child;
         end
      endfunction

      function void note_request(req_type it);
         rsp_type   r;
         entry_type e;
         r        = '0;
         r.status = STATUS_DONE;
         if (it.opcode == OPC_PUSH) begin
            if (fill >= HEAP_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               e.key    = it.new_key;
               e.source = it.new_source;
               e.dest   = it.new_dest;
               fill++;
               slots[fill] = e;
               rise(fill);
            end
         end else if (fill == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.removed_key    = slots[1].key;
            r.removed_source = slots[1].source;
            r.removed_dest   = slots[1].dest;
            slots[1] = slots[fill];
            fill--;
            sink();
         end
         if (fill != 0) begin
            r.top_key    = slots[1].key;
            r.top_source = slots[1].source;
            r.top_dest   = slots[1].dest;
         end
         r.entry_count = COUNT_W'(fill);
         r.heap_empty  = (fill == 0);
         awaited.push_back(r);
      endfunction

      function void report(string what, longint expd, longint act);
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expd, act);
         mismatches++;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status)
            report("status", want.status, got.status);
         if (got.removed_key !== want.removed_key)
            report("removed_key", want.removed_key, got.removed_key);
         if (got.removed_source !== want.removed_source)
            report("removed_source", want.removed_source, got.removed_source);
         if (got.removed_dest !== want.removed_dest)
            report("removed_dest", want.removed_dest, got.removed_dest);
         if (got.top_key !== want.top_key)
            report("top_key", want.top_key, got.top_key);
         if (got.top_source !== want.top_source)
            report("top_source", want.top_source, got.top_source);
         if (got.top_dest !== want.top_dest)
            report("top_dest", want.top_dest, got.top_dest);
         if (got.entry_count !== want.entry_count)
            report("entry_count", want.entry_count, got.entry_count);
         if (got.heap_empty !== want.heap_empty)
            report("heap_empty", want.heap_empty, got.heap_empty);
      endfunction
   endclass

endpackage

// ----- bench/binary_min_heap_queue_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives push/pop transactions into the heap queue and checks every response.
module binary_min_heap_queue_top_tb;
   import bmhq_pkg::*;
   import bmhq_tb_pkg::*;

   localparam int  RESET_CYCLES  = 12;
   localparam int  HOLD_CYCLES   = 300;  // long receiver hold-off
   localparam int  SETTLE_CYCLES = 40;   // > worst-case latency
   localparam time TIMEOUT_NS    = 7_200_000;  // far above the slowest legal run
   localparam int unsigned GROW_TARGET = 480;  // deep heap, nine levels

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // control shared between the driver and the receiver process
   bit quiet        = 1'b0;  // no idling on either side
   bit hold_off_req = 1'b0;  // ask the receiver for one long stall

   heap_shadow shadow;

   always #6 clock = ~clock;

   binary_min_heap_queue_top #(
      .CAPACITY (HEAP_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Keys: full random for bit coverage, a tight band to force ties,
   // the signed corners, and a moderate band around zero.
   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 8)) - 4;
         2: begin
            case ($urandom_range(0, 5))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7fff_ffff;
               2:       return 32'sh8000_0001;
               3:       return -1;
               4:       return 1;
               default: return 0;
            endcase
         end
         default: return $signed($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   // Random transaction; pops carry random payload too, which the block ignores.
   function automatic req_type make_item(int push_pct);
      req_type it;
      it.opcode     = ($urandom_range(0, 99) < push_pct) ? OPC_PUSH : OPC_POP;
      it.new_key    = pick_key();
      it.new_source = VERT_W'($urandom);
      it.new_dest   = VERT_W'($urandom);
      return it;
   endfunction

   function automatic req_type push_of(logic signed [KEY_W-1:0] k,
                                       logic [VERT_W-1:0] s, logic [VERT_W-1:0] d);
      req_type it;
      it.opcode     = OPC_PUSH;
      it.new_key    = k;
      it.new_source = s;
      it.new_dest   = d;
      return it;
   endfunction

   function automatic req_type pop_of();
      req_type it;
      it        = '0;
      it.opcode = OPC_POP;
      return it;
   endfunction

   // Offer one transaction and hold it until accepted. Called at a rising edge.
   // An optional idle burst comes first; valid is only lowered when a gap is
   // inserted, so back-to-back transactions never toggle valid within a step.
   task automatic send_req(req_type it);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_ready !== 1'b1);
      shadow.note_request(it);
   endtask

   // Sender pause: nothing offered until every awaited response is back.
   task automatic await_drain();
      req_valid <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   task automatic mixed_burst(int count, int push_pct);
      repeat (count) send_req(make_item(push_pct));
   endtask

   // Directed opening: refused pop on empty, the key corners, equal keys
   // (no swap on ties going up, left child wins going down), and a full
   // drain ending in another refused pop.
   task automatic directed_part();
      send_req(pop_of());
      send_req(push_of(0, 16'h0000, 16'h0000));
      send_req(push_of(32'sh7fff_ffff, 16'hffff, 16'hffff));
      send_req(push_of(32'sh8000_0000, 16'h0001, 16'h0002));
      send_req(push_of(-1, 16'haaaa, 16'h5555));
      send_req(push_of(1, 16'h5555, 16'haaaa));
      send_req(push_of(-1, 16'h1234, 16'h4321));
      send_req(push_of(32'sh8000_0000, 16'hffff, 16'h0000));
      repeat (4) send_req(pop_of());
      for (int i = 1; i <= 4; i++) send_req(push_of(5, VERT_W'(i), VERT_W'(16 - i)));
      repeat (8) send_req(pop_of());
   endtask

   // Push-heavy until the heap is deep, then churn at the top.
   task automatic grow_heap();
      while (shadow.held() < GROW_TARGET) send_req(make_item(97));
      repeat (20) send_req(make_item(60));
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      shadow = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      directed_part();
      mixed_burst(100, 50);        // small heap, frequent empty pops

      // Long receiver stall while we keep offering: the block backs up and
      // stops taking transactions, then we wait for everything to come out.
      hold_off_req = 1'b1;
      mixed_burst(30, 70);
      await_drain();

      grow_heap();                 // deep sifts
      mixed_burst(80, 15);         // pop-heavy from a large heap

      quiet = 1'b1;                // final stretch with no idling at all
      mixed_burst(60, 50);

      await_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random ready bursts, one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      wait (reset == 1'b0);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // Response monitor: one check per accepted response transaction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         shadow.check_response(rsp_data);
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
